// ===== src/lse_pkg.sv =====
package lse_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);

	typedef logic [AW-1:0]        addr_t;
	typedef logic [CW-1:0]        cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [3:0] {
		F_PUSH  = 4'd0,
		F_POP   = 4'd1,
		F_TOP   = 4'd2,
		F_CLEAR = 4'd3,
		F_SIZE  = 4'd4,
		F_MIN   = 4'd5,
		F_REV   = 4'd6,
		F_SUM   = 4'd7,
		F_DEL   = 4'd8,
		F_DEDUP = 4'd9,
		F_SYM   = 4'd10
	} func_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_RDW,
		S_MINW,
		S_SUMW,
		S_REVA,
		S_REVW,
		S_DELW,
		S_DDI,
		S_DDIW,
		S_DDJW,
		S_SYMA,
		S_SYMW,
		S_OUT
	} state_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic  re;
		addr_t raddr;
		logic  we;
		addr_t waddr;
		word_t wdata;
	} mem_req_t;

endpackage

// ===== src/lse_ram.sv =====
module lse_ram import lse_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output word_t    rdata
);

	word_t mem [DEPTH];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== src/lifo_stack_engine_with_queries.sv =====
// LIFO stack engine with queries.
// Input channel: in_valid/in_stall carry func, value, count_k, range_low,
// range_high. Output channel: out_valid/out_stall carry status, data,
// size_now and flag. Every item gives exactly one result.
// The entries live in one synchronous RAM with a registered read port.
// Push, clear, size and unused codes go from accept straight to the result
// state; pop and top first read the top entry. Min and range sum walk the
// stack one entry a cycle. Reverse reads the low and the high entry and then
// writes both for each swapped pair; symmetry reads and compares each pair.
// Delete walks the stack once. Dedup compares each entry against every
// kept entry below it, all bound by the single read port.
// One item is in work at a time; the next is taken once the controller is
// idle and the result register is free.
// Reset clears the fill count and the controller; the RAM contents
// are not cleared. When the receiver stalls, the result holds in its output
// register and no new item is taken.
module lifo_stack_engine_with_queries import lse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic signed [31:0] value,
	input  logic [6:0]  count_k,
	input  logic [6:0]  range_low,
	input  logic [6:0]  range_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] data,
	output logic [6:0]  size_now,
	output logic        flag
);

	mem_req_t req;
	word_t    rdata;

	lse_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	state_t state_q, state_d;
	cnt_t   n_q, n_d;
	logic [3:0] f_q, f_d;
	word_t  v_q, v_d;
	cnt_t   hi_q, hi_d;
	cnt_t   i_q, i_d, j_q, j_d, w_q, w_d;
	word_t  acc_q, acc_d, t_q, t_d;
	logic [1:0] st_q, st_d;
	logic   fl_q, fl_d;
	logic   ov_q, ov_d;

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			ov_q    <= ov_d;
		end
	end

	// Working registers, no reset needed.
	always_ff @(posedge clk) begin
		f_q   <= f_d;
		v_q   <= v_d;
		hi_q  <= hi_d;
		i_q   <= i_d;
		j_q   <= j_d;
		w_q   <= w_d;
		acc_q <= acc_d;
		t_q   <= t_d;
		st_q  <= st_d;
		fl_q  <= fl_d;
	end

	assign in_stall  = (state_q != S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign status    = st_q;
	assign data      = acc_q;
	assign size_now  = 7'(n_q);
	assign flag      = fl_q;

	// Sequencer: next state, memory requests and result.
	always_comb begin
		state_d = state_q;
		n_d = n_q; f_d = f_q; v_d = v_q; hi_d = hi_q;
		i_d = i_q; j_d = j_q; w_d = w_q; acc_d = acc_q; t_d = t_q;
		st_d = st_q; fl_d = fl_q; ov_d = ov_q;
		req = '0;
		if (ov_q && !out_stall) begin
			ov_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !ov_q) begin
					f_d = func; v_d = value;
					hi_d = CW'(range_high);
					st_d = ST_OK; fl_d = 1'b0; acc_d = '0;
					state_d = S_OUT;
					unique case (func)
						F_PUSH: begin
							if (n_q >= CW'(DEPTH)) begin
								st_d = ST_FULL;
							end else begin
								req.we = 1'b1; req.waddr = AW'(n_q); req.wdata = value;
								n_d = n_q + 1'b1;
							end
						end
						F_POP, F_TOP: begin
							if (n_q == 0) st_d = ST_EMPTY;
							else state_d = S_RD;
						end
						F_CLEAR: n_d = '0;
						F_SIZE:  fl_d = (n_q == 0);
						F_MIN: begin
							if (n_q == 0) begin
								st_d = ST_EMPTY;
							end else begin
								i_d = '0; state_d = S_RD;
							end
						end
						F_REV: begin
							if (CW'(count_k) > n_q) begin
								st_d = ST_RANGE;
							end else if (count_k > 7'd1) begin
								i_d = n_q - CW'(count_k); j_d = n_q - 1'b1;
								state_d = S_REVA;
							end
						end
						F_SUM: begin
							if (range_low == 0 || range_high < range_low ||
							    CW'(range_high) > n_q) begin
								st_d = ST_RANGE;
							end else begin
								i_d = CW'(range_low) - 1'b1; state_d = S_RD;
							end
						end
						F_DEL: begin
							i_d = '0; w_d = '0;
							if (n_q != 0) state_d = S_RD;
						end
						F_DEDUP: begin
							i_d = '0; w_d = '0;
							if (n_q != 0) state_d = S_DDI;
						end
						F_SYM: begin
							fl_d = 1'b1; i_d = '0; j_d = n_q - 1'b1;
							if (n_q > 1) state_d = S_SYMA;
						end
						default: st_d = ST_RANGE;
					endcase
				end
			end
			// First read of a walk, or the read of the top entry for pop and top.
			S_RD: begin
				req.re = 1'b1;
				if (f_q == F_POP || f_q == F_TOP) begin
					req.raddr = AW'(n_q - 1'b1);
					state_d = S_RDW;
				end else begin
					req.raddr = AW'(i_q);
					i_d = i_q + 1'b1;
					unique case (f_q)
						F_MIN:   state_d = S_MINW;
						F_SUM:   state_d = S_SUMW;
						default: state_d = S_DELW;
					endcase
				end
			end
			S_RDW: begin
				acc_d = rdata;
				if (f_q == F_POP) n_d = n_q - 1'b1;
				state_d = S_OUT;
			end
			// Minimum: one entry a cycle, next read overlapped.
			S_MINW: begin
				if (i_q == CW'(1) || $signed(rdata) < $signed(acc_q)) acc_d = rdata;
				if (i_q < n_q) begin
					req.re = 1'b1; req.raddr = AW'(i_q); i_d = i_q + 1'b1;
				end else begin
					i_d = i_q + 1'b1;
					state_d = S_OUT;
				end
			end
			S_SUMW: begin
				acc_d = acc_q + rdata;
				if (i_q < hi_q) begin
					req.re = 1'b1; req.raddr = AW'(i_q); i_d = i_q + 1'b1;
				end else begin
					state_d = S_OUT;
				end
			end
			// Delete: compact entries not equal to the value.
			S_DELW: begin
				if (rdata != v_q) begin
					req.we = 1'b1; req.waddr = AW'(w_q); req.wdata = rdata;
					w_d = w_q + 1'b1;
				end
				if (i_q < n_q) begin
					req.re = 1'b1; req.raddr = AW'(i_q); i_d = i_q + 1'b1;
				end else begin
					n_d = (rdata != v_q) ? w_q + 1'b1 : w_q;
					state_d = S_OUT;
				end
			end
			// Reverse: read low entry, then high entry, then swap writes.
			S_REVA: begin
				req.re = 1'b1; req.raddr = AW'(i_q);
				state_d = S_REVW;
			end
			S_REVW: begin
				t_d = rdata;
				req.re = 1'b1; req.raddr = AW'(j_q);
				state_d = S_SYMW;
			end
			// Symmetry: read the low entry; S_REVW and S_SYMW are shared with reverse.
			S_SYMA: begin
				req.re = 1'b1; req.raddr = AW'(i_q);
				state_d = S_REVW;
			end
			S_SYMW: begin
				if (f_q == F_REV) begin
					req.we = 1'b1; req.waddr = AW'(i_q); req.wdata = rdata;
					acc_d = acc_q;
					t_d = t_q;
					state_d = S_DDJW;
				end else begin
					if (rdata != t_q) begin
						fl_d = 1'b0; state_d = S_OUT;
					end else if (i_q + 1'b1 < j_q - 1'b1) begin
						i_d = i_q + 1'b1; j_d = j_q - 1'b1; state_d = S_SYMA;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			// Dedup: t holds candidate entries[i]; compare against kept 0..w-1.
			S_DDI: begin
				req.re = 1'b1; req.raddr = AW'(i_q);
				state_d = S_DDIW;
			end
			S_DDIW: begin
				t_d = rdata; j_d = '0;
				if (w_q == 0) begin
					req.we = 1'b1; req.waddr = AW'(w_q); req.wdata = rdata;
					w_d = w_q + 1'b1; i_d = i_q + 1'b1;
					state_d = (i_q + 1'b1 < n_q) ? S_DDI : S_OUT;
					if (i_q + 1'b1 >= n_q) n_d = w_q + 1'b1;
				end else begin
					req.re = 1'b1; req.raddr = '0; j_d = CW'(1);
					state_d = S_DDJW;
				end
			end
			S_DDJW: begin
				if (f_q == F_REV) begin
					// Second half of the swap: high entry takes the saved low one.
					req.we = 1'b1; req.waddr = AW'(j_q); req.wdata = t_q;
					if (i_q + 1'b1 < j_q - 1'b1) begin
						i_d = i_q + 1'b1; j_d = j_q - 1'b1; state_d = S_REVA;
					end else begin
						state_d = S_OUT;
					end
				end else if (rdata == t_q) begin
					i_d = i_q + 1'b1;
					if (i_q + 1'b1 < n_q) state_d = S_DDI;
					else begin
						n_d = w_q; state_d = S_OUT;
					end
				end else if (j_q < w_q) begin
					req.re = 1'b1; req.raddr = AW'(j_q); j_d = j_q + 1'b1;
				end else begin
					req.we = 1'b1; req.waddr = AW'(w_q); req.wdata = t_q;
					w_d = w_q + 1'b1; i_d = i_q + 1'b1;
					if (i_q + 1'b1 < n_q) state_d = S_DDI;
					else begin
						n_d = w_q + 1'b1; state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				ov_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== bench/lifo_stack_engine_with_queries_tb.sv =====
module lifo_stack_engine_with_queries_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lse_pkg::*;

	typedef struct {
		logic [3:0]         op;
		logic signed [31:0] word;
		logic [6:0]         k;
		logic [6:0]         lo;
		logic [6:0]         hi;
	} request_t;

	typedef struct {
		logic [1:0]         st;
		logic signed [31:0] word;
		logic [6:0]         fill;
		logic               flg;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] func = '0;
	logic signed [31:0] value = '0;
	logic [6:0] count_k = '0;
	logic [6:0] range_low = '0;
	logic [6:0] range_high = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [31:0] data;
	logic [6:0] size_now;
	logic flag;

	lifo_stack_engine_with_queries dut (.*);

	request_t pending_reqs[$];
	reply_t   expected_replies[$];
	int       errors = 0;
	int       cycles = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       hold_recv = 0;
	bit       send_pause = 1'b0;
	bit       in_taken = 1'b0;

	// Predictor copy of the stack.
	logic signed [31:0] model_stack[DEPTH];
	int model_fill = 0;

	function automatic reply_t predict_reply(request_t r);
		reply_t o;
		int i, j, w;
		logic signed [31:0] t, s;
		bit seen;
		o.st = ST_OK; o.word = '0; o.flg = 1'b0;
		case (r.op)
			F_PUSH: begin
				if (model_fill >= DEPTH) o.st = ST_FULL;
				else begin
					model_stack[model_fill] = r.word;
					model_fill++;
				end
			end
			F_POP, F_TOP, F_MIN: begin
				if (model_fill == 0) o.st = ST_EMPTY;
				else if (r.op == F_MIN) begin
					o.word = model_stack[0];
					for (i = 1; i < model_fill; i++)
						if (model_stack[i] < o.word) o.word = model_stack[i];
				end else begin
					o.word = model_stack[model_fill-1];
					if (r.op == F_POP) model_fill--;
				end
			end
			F_CLEAR: model_fill = 0;
			F_SIZE: o.flg = (model_fill == 0);
			F_REV: begin
				if (r.k > model_fill) o.st = ST_RANGE;
				else if (r.k > 1) begin
					i = model_fill - r.k;
					j = model_fill - 1;
					while (i < j) begin
						t = model_stack[i];
						model_stack[i] = model_stack[j];
						model_stack[j] = t;
						i++; j--;
					end
				end
			end
			F_SUM: begin
				if (r.lo < 1 || r.hi < r.lo || r.hi > model_fill) o.st = ST_RANGE;
				else begin
					s = '0;
					for (i = r.lo - 1; i < r.hi; i++) s = s + model_stack[i];
					o.word = s;
				end
			end
			F_DEL: begin
				w = 0;
				for (i = 0; i < model_fill; i++)
					if (model_stack[i] != r.word) begin
						model_stack[w] = model_stack[i];
						w++;
					end
				model_fill = w;
			end
			F_DEDUP: begin
				w = 0;
				for (i = 0; i < model_fill; i++) begin
					seen = 1'b0;
					for (j = 0; j < w; j++)
						if (model_stack[j] == model_stack[i]) seen = 1'b1;
					if (!seen) begin
						model_stack[w] = model_stack[i];
						w++;
					end
				end
				model_fill = w;
			end
			F_SYM: begin
				o.flg = 1'b1;
				for (i = 0; i < model_fill / 2; i++)
					if (model_stack[i] != model_stack[model_fill-1-i]) o.flg = 1'b0;
			end
			default: o.st = ST_RANGE;
		endcase
		o.fill = model_fill[6:0];
		return o;
	endfunction

	task automatic add_req(logic [3:0] op, logic signed [31:0] w = 0,
			int k = 0, int lo = 0, int hi = 0);
		request_t r;
		r.op = op; r.word = w; r.k = 7'(k); r.lo = 7'(lo); r.hi = 7'(hi);
		pending_reqs.push_back(r);
	endtask

	// Values drawn from a small pool so that deletes, dedup and symmetry hit.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 5);
			1: return 32'sh7fff_ffff - $urandom_range(0, 1);
			2: return 32'sh8000_0000 + $urandom_range(0, 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random_req();
		int pick;
		logic [3:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 40) op = F_PUSH;
		else if (pick < 50) op = F_POP;
		else if (pick < 98) op = 4'($urandom_range(1, 10));
		else op = 4'($urandom_range(11, 15));
		add_req(op, pick_word(), $urandom_range(0, 70),
			$urandom_range(0, 66), $urandom_range(0, 66));
		// Occasional fully random arguments to flip every bit.
		if ($urandom_range(0, 19) == 0) begin
			pending_reqs[$].k = 7'($urandom);
			pending_reqs[$].lo = 7'($urandom);
			pending_reqs[$].hi = 7'($urandom);
		end
	endtask

	initial begin
		forever #2ns clk = ~clk;
	end

	// Driver: inputs move on the falling edge; an offered item holds until taken.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken <= 1'b0;
			if (pending_reqs.size() != 0 && !send_pause && arst_n &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				func <= pending_reqs[0].op;
				value <= pending_reqs[0].word;
				count_k <= pending_reqs[0].k;
				range_low <= pending_reqs[0].lo;
				range_high <= pending_reqs[0].hi;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (hold_recv > 0) begin
			out_stall <= 1'b1;
			hold_recv <= hold_recv - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Monitor: sample both channels on the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && !in_stall) begin
			expected_replies.push_back(predict_reply(pending_reqs.pop_front()));
			in_taken <= 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				reply_t e;
				e = expected_replies.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (data !== e.word) begin
					$error("data expected %0d actual %0d", e.word, data);
					errors++;
				end
				if (size_now !== e.fill) begin
					$error("size_now expected %0d actual %0d", e.fill, size_now);
					errors++;
				end
				if (flag !== e.flg) begin
					$error("flag expected %0d actual %0d", e.flg, flag);
					errors++;
				end
			end
		end
		if (cycles > 10000000) begin
			$display("lifo_stack_engine_with_queries verification failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty cases, extremes, every operation.
		add_req(F_POP); add_req(F_TOP); add_req(F_MIN); add_req(F_SIZE);
		add_req(F_SYM); add_req(F_DEL, 5); add_req(F_DEDUP); add_req(F_SUM, 0, 0, 1, 1);
		add_req(F_PUSH, 32'sh7fff_ffff); add_req(F_PUSH, 32'sh8000_0000);
		add_req(F_PUSH, 32'sh7fff_ffff); add_req(F_SYM); add_req(F_SUM, 0, 0, 1, 3);
		add_req(F_SUM, 0, 0, 0, 2); add_req(F_SUM, 0, 0, 3, 2); add_req(F_SUM, 0, 0, 1, 4);
		add_req(F_MIN); add_req(F_REV, 0, 4); add_req(F_REV, 0, 1); add_req(F_REV, 0, 3);
		add_req(F_DEDUP); add_req(F_DEL, 32'sh8000_0000); add_req(4'd11); add_req(4'd15);
		add_req(F_CLEAR);
		drain();

		// Fill to full and push beyond, then reverse the whole stack.
		for (int i = 0; i < DEPTH + 2; i++) add_req(F_PUSH, pick_word());
		add_req(F_REV, 0, DEPTH); add_req(F_SUM, 0, 0, 1, DEPTH);
		add_req(F_REV, 0, 127); add_req(F_SIZE);
		drain();

		// Random phases under the three idling patterns.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 86 : 0;
			recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 17 : 0;
			for (int n = 0; n < 400; n++) begin
				add_random_req();
				if ($urandom_range(0, 99) == 0) add_req(F_CLEAR);
			end
			if (ph == 2) hold_recv = 300;
			drain();
			// Sender pause with nothing outstanding.
			send_pause = 1'b1;
			repeat (20) @(posedge clk);
			send_pause = 1'b0;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_replies.size() == 0)
			$display("lifo_stack_engine_with_queries verification clean");
		else
			$display("lifo_stack_engine_with_queries verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
src/lse_pkg.sv
src/lse_ram.sv
src/lifo_stack_engine_with_queries.sv
bench/lifo_stack_engine_with_queries_tb.sv
